>>> rtl/core/tfes_pkg.sv
package tfes_pkg;

  // Item kinds carried on the slave-side tuser
  typedef enum logic [1:0] {
    OP_CONTACT   = 2'd0,
    OP_EMPTY_END = 2'd1,
    OP_CANCEL    = 2'd2,
    OP_RESERVED  = 2'd3
  } op_e;

  // Configuration register indexes
  localparam logic CFG_EDGE_BAND   = 1'b0;
  localparam logic CFG_OPEN_TRAVEL = 1'b1;
  localparam int unsigned CFG_W    = 12;

  localparam int unsigned FINGER_SLOTS = 2;
  localparam int unsigned ID_W         = 8;
  localparam int unsigned UP_SLOP      = 8;
  localparam int unsigned SIDE_SLOP    = 24;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] EDGE_BAND_RST   = 12'd56;
  localparam logic [CFG_W-1:0] OPEN_TRAVEL_RST = 12'd96;

  // Reciprocal of three for values below 2^16: n/3 = (n * DIV3_MUL) >> DIV3_SHIFT
  localparam logic [15:0] DIV3_MUL   = 16'hAAAB;
  localparam int unsigned DIV3_SHIFT = 17;

  localparam int unsigned OUT_TDATA_W = 8;

  // Non-coordinate fields of one input item
  typedef struct packed {
    op_e             opcode;
    logic [ID_W-1:0] finger_id;
    logic            pressed;
    logic            frame_end;
    logic            panel_open;
  } ctl_t;

  // One result item; claimed sits in the lowest bit
  typedef struct packed {
    logic open_request;
    logic claimed;
  } res_t;

endpackage

>>> rtl/core/tfes_in_stage.sv
module tfes_in_stage #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  tfes_pkg::ctl_t        ctl_i,
  input  logic [COORD_BITS-1:0] pos_x_i,
  input  logic [COORD_BITS-1:0] pos_y_i,
  input  logic                  proc_i,
  output logic                  valid_o,
  output tfes_pkg::ctl_t        ctl_o,
  output logic [COORD_BITS-1:0] pos_x_o,
  output logic [COORD_BITS-1:0] pos_y_o
);
  import tfes_pkg::*;

  logic                  valid_q, valid_d;
  ctl_t                  ctl_q;
  logic [COORD_BITS-1:0] x_q, y_q;
  logic                  load;

  // Take a new item whenever the held one is empty or leaves this cycle
  assign ready_o = !valid_q || proc_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (proc_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload of the accepted item
  always_ff @(posedge clk_i) begin
    if (load) begin
      ctl_q <= ctl_i;
      x_q   <= pos_x_i;
      y_q   <= pos_y_i;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign pos_x_o = x_q;
  assign pos_y_o = y_q;

endmodule

>>> rtl/core/tfes_tracker.sv
module tfes_tracker #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_addr_i,
  input  logic [tfes_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                   proc_i,
  input  tfes_pkg::ctl_t         ctl_i,
  input  logic [COORD_BITS-1:0]  pos_x_i,
  input  logic [COORD_BITS-1:0]  pos_y_i,
  output logic                   res_valid_o,
  output tfes_pkg::res_t         res_o
);
  import tfes_pkg::*;

  localparam int unsigned CW = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 3;
  localparam logic signed [CW-1:0] UP_S   = CW'(UP_SLOP);
  localparam logic signed [CW-1:0] SIDE_S = CW'(SIDE_SLOP);

  function automatic logic signed [CW-1:0] ext_c(input logic [COORD_BITS-1:0] v);
    return $signed({{(CW-COORD_BITS){1'b0}}, v});
  endfunction

  function automatic logic signed [CW-1:0] ext_r(input logic [CFG_W-1:0] v);
    return $signed({{(CW-CFG_W){1'b0}}, v});
  endfunction

  // Configuration and the derived two-thirds threshold
  logic [CFG_W-1:0]  band_q, open_q, part_q;
  logic [CFG_W:0]    twice_w;
  logic [CFG_W+16:0] prod_w;

  assign twice_w = {cfg_wdata_i, 1'b0};
  assign prod_w  = {{16{1'b0}}, twice_w} * {{(CFG_W+1){1'b0}}, DIV3_MUL};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q <= EDGE_BAND_RST;
      open_q <= OPEN_TRAVEL_RST;
      part_q <= CFG_W'(({1'b0, OPEN_TRAVEL_RST} * 2) / 3);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_EDGE_BAND: band_q <= cfg_wdata_i;
        CFG_OPEN_TRAVEL: begin
          open_q <= cfg_wdata_i;
          part_q <= prod_w[DIV3_SHIFT +: CFG_W];
        end
        default: band_q <= band_q;
      endcase
    end
  end

  // Finger slots and gesture flags
  logic [ID_W-1:0]       id_q   [FINGER_SLOTS];
  logic [ID_W-1:0]       id_d   [FINGER_SLOTS];
  logic [COORD_BITS-1:0] sx_q   [FINGER_SLOTS];
  logic [COORD_BITS-1:0] sx_d   [FINGER_SLOTS];
  logic [COORD_BITS-1:0] sy_q   [FINGER_SLOTS];
  logic [COORD_BITS-1:0] sy_d   [FINGER_SLOTS];
  logic [COORD_BITS-1:0] cx_q   [FINGER_SLOTS];
  logic [COORD_BITS-1:0] cx_d   [FINGER_SLOTS];
  logic [COORD_BITS-1:0] cy_q   [FINGER_SLOTS];
  logic [COORD_BITS-1:0] cy_d   [FINGER_SLOTS];
  logic [FINGER_SLOTS-1:0] act_q, act_d, path_q, path_d, match;
  logic track_q, track_d, elig_q, elig_d, claim_q, claim_d, opened_q, opened_d;

  logic                 hit_found, free_found, slot, evaluate, req;
  logic signed [CW-1:0] dy, dx, d0, d1, dsum;

  always_comb begin
    for (int i = 0; i < FINGER_SLOTS; i++) begin
      match[i] = act_q[i] && (id_q[i] == ctl_i.finger_id);
    end
  end
  assign hit_found  = |match;
  assign free_found = !(&act_q);

  // Apply one item to the slots, then score the frame if it ends here
  always_comb begin
    id_d     = id_q;
    sx_d     = sx_q;
    sy_d     = sy_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    act_d    = act_q;
    path_d   = path_q;
    track_d  = track_q;
    elig_d   = elig_q;
    claim_d  = claim_q;
    opened_d = opened_q;
    slot     = hit_found ? !match[0] : act_q[0];
    dy       = '0;
    dx       = '0;
    d0       = '0;
    d1       = '0;
    dsum     = '0;
    evaluate = 1'b0;
    req      = 1'b0;

    case (ctl_i.opcode)
      OP_CONTACT: begin
        evaluate = ctl_i.frame_end;
        if (ctl_i.pressed) begin
          if (!hit_found && !free_found) begin
            // third finger: no slot, gesture spoilt
            elig_d = 1'b0;
          end else begin
            if (!hit_found) begin
              id_d[slot]   = ctl_i.finger_id;
              sx_d[slot]   = pos_x_i;
              sy_d[slot]   = pos_y_i;
              path_d[slot] = 1'b1;
              act_d[slot]  = 1'b1;
            end
            cx_d[slot] = pos_x_i;
            cy_d[slot] = pos_y_i;
            dy = ext_c(pos_y_i) - ext_c(sy_d[slot]);
            dx = ext_c(pos_x_i) - ext_c(sx_d[slot]);
            if (dx < 0) begin
              dx = -dx;
            end
            if ((dy < -UP_S) || (dx > dy + SIDE_S)) begin
              path_d[slot] = 1'b0;
              if (track_q) begin
                elig_d = 1'b0;
              end
            end
            if ((&act_d) && !track_q) begin
              track_d  = 1'b1;
              elig_d   = (ext_c(sy_d[0]) <= ext_r(band_q)) &&
                         (ext_c(sy_d[1]) <= ext_r(band_q)) && path_d[0] && path_d[1];
              claim_d  = elig_d;
              opened_d = 1'b0;
            end
          end
        end else if (hit_found) begin
          cx_d[slot]  = pos_x_i;
          cy_d[slot]  = pos_y_i;
          act_d[slot] = 1'b0;
          if (track_q) begin
            elig_d = 1'b0;
          end
        end
      end
      OP_EMPTY_END: evaluate = 1'b1;
      OP_CANCEL: begin
        act_d    = '0;
        track_d  = 1'b0;
        elig_d   = 1'b0;
        claim_d  = 1'b0;
        opened_d = 1'b0;
      end
      default: evaluate = 1'b0;
    endcase

    if (evaluate) begin
      d0   = ext_c(cy_d[0]) - ext_c(sy_d[0]);
      d1   = ext_c(cy_d[1]) - ext_c(sy_d[1]);
      dsum = (d0 + d1) >>> 1;
      req  = track_d && elig_d && !opened_d && !ctl_i.panel_open && (&act_d) &&
             (d0 >= 0) && (d1 >= 0) && path_d[0] && path_d[1] &&
             (d0 >= ext_r(part_q)) && (d1 >= ext_r(part_q)) &&
             (dsum >= ext_r(open_q));
      if (req) begin
        opened_d = 1'b1;
      end
    end

    res_o.claimed      = claim_d;
    res_o.open_request = req;

    // No finger left: drop the whole gesture
    if (evaluate && (act_d == '0)) begin
      track_d  = 1'b0;
      elig_d   = 1'b0;
      claim_d  = 1'b0;
      opened_d = 1'b0;
    end
  end

  assign res_valid_o = proc_i && evaluate;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= '0;
      path_q   <= '0;
      track_q  <= 1'b0;
      elig_q   <= 1'b0;
      claim_q  <= 1'b0;
      opened_q <= 1'b0;
      for (int i = 0; i < FINGER_SLOTS; i++) begin
        id_q[i] <= '0;
        sx_q[i] <= '0;
        sy_q[i] <= '0;
        cx_q[i] <= '0;
        cy_q[i] <= '0;
      end
    end else if (proc_i) begin
      act_q    <= act_d;
      path_q   <= path_d;
      track_q  <= track_d;
      elig_q   <= elig_d;
      claim_q  <= claim_d;
      opened_q <= opened_d;
      id_q     <= id_d;
      sx_q     <= sx_d;
      sy_q     <= sy_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
    end
  end

endmodule

>>> rtl/core/tfes_out_stage.sv
module tfes_out_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  tfes_pkg::res_t                      res_i,
  input  logic                                ready_i,
  output logic                                valid_o,
  output logic [tfes_pkg::OUT_TDATA_W-1:0]    data_o
);
  import tfes_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // Keep the item until the sink takes it
  assign valid_d = load_i ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = {{(OUT_TDATA_W-$bits(res_t)){1'b0}}, res_q};

endmodule

>>> rtl/core/two_finger_edge_swipe_detector.sv
// Two-finger top-edge swipe detector. Touch reports enter on the slave stream
// (tuser selects contact report, empty frame end or cancel; tlast marks the last
// report of a frame) and one result item (claimed, open_request) leaves on the
// master stream for every frame end. Each item is held in the input register,
// is applied to the two finger slots combinationally and lands in the output
// register. One item is taken every cycle while the sink keeps up; a stalled
// output register holds the pipe. Write cfg registers only while no item is in
// flight: index 0 is the edge band height, index 1 the open travel.
module two_finger_edge_swipe_detector #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_addr_i,
  input  logic [tfes_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // finger_id, pos_x, pos_y, pressed, panel_open, zero fill
  input  logic [((2*COORD_BITS+10+7)/8)*8-1:0] s_axis_tdata,
  // opcode
  input  logic [1:0]                         s_axis_tuser,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // claimed, open_request, zero fill
  output logic [tfes_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import tfes_pkg::*;

  localparam int unsigned X_LSB  = ID_W;
  localparam int unsigned Y_LSB  = ID_W + COORD_BITS;
  localparam int unsigned PR_BIT = ID_W + 2 * COORD_BITS;
  localparam int unsigned PO_BIT = PR_BIT + 1;

  ctl_t                  s_ctl, h_ctl;
  logic [COORD_BITS-1:0] h_x, h_y;
  logic                  h_valid, proc, res_valid;
  res_t                  res;

  // Unpack the incoming item
  always_comb begin
    s_ctl.opcode     = op_e'(s_axis_tuser);
    s_ctl.finger_id  = s_axis_tdata[ID_W-1:0];
    s_ctl.pressed    = s_axis_tdata[PR_BIT];
    s_ctl.frame_end  = s_axis_tlast;
    s_ctl.panel_open = s_axis_tdata[PO_BIT];
  end

  // Advance the held item when the output register can take a result
  assign proc = h_valid && (!m_axis_tvalid || m_axis_tready);

  tfes_in_stage #(.COORD_BITS(COORD_BITS)) u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .ctl_i   (s_ctl),
    .pos_x_i (s_axis_tdata[X_LSB +: COORD_BITS]),
    .pos_y_i (s_axis_tdata[Y_LSB +: COORD_BITS]),
    .proc_i  (proc),
    .valid_o (h_valid),
    .ctl_o   (h_ctl),
    .pos_x_o (h_x),
    .pos_y_o (h_y)
  );

  tfes_tracker #(.COORD_BITS(COORD_BITS)) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .proc_i      (proc),
    .ctl_i       (h_ctl),
    .pos_x_i     (h_x),
    .pos_y_i     (h_y),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tfes_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (m_axis_tdata)
  );

endmodule

>>> rtl/core/tfes_checker.sv
module tfes_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [tfes_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // An open request only comes with a claimed gesture
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("open request on unclaimed gesture");

  // A fresh result follows an accepted item through the input and output registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without an accepted item");

  // Two back-to-back results cannot both open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tdata[1] |=>
      !(m_axis_tvalid && m_axis_tdata[1]))
    else $error("repeated open request");

endmodule

bind two_finger_edge_swipe_detector tfes_checker u_tfes_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
